FILE: hdl/fat_entry_table_allocator_assert.svh
// ============================================================================
// Assertion macros for the FAT entry table allocator
// Concurrent checks clocked on i_clk, disabled while i_rst_n is low.
// ============================================================================
`ifndef FAT_ENTRY_TABLE_ALLOCATOR_ASSERT_SVH
`define FAT_ENTRY_TABLE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FETA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FETA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/feta_pkg.sv
// ============================================================================
// feta_pkg
// Widths, codes, control word layout and microcode table of the allocator.
// ============================================================================
`default_nettype none

package feta_pkg;

    localparam int ENTRIES = 4096;
    localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 28;
    localparam int CMD_W   = 2;
    localparam int ST_W    = 2;
    localparam int CC_W    = 13;
    localparam int CFG_A_W = 2;
    localparam int SCAN_W  = (ADDR_W + 1 > CC_W) ? ADDR_W + 1 : CC_W;
    localparam int PC_W    = 4;

    localparam logic [IDX_W:0]    ENTRIES_IX = (IDX_W + 1)'(ENTRIES);
    localparam logic [SCAN_W-1:0] ENTRIES_SC = SCAN_W'(ENTRIES);
    localparam logic [SCAN_W-1:0] LAST_SC    = SCAN_W'(ENTRIES - 1);

    localparam logic [CC_W-1:0]   CC_RESET   = CC_W'(4096);
    localparam logic [DATA_W-1:0] FREE_RESET = 32'h0000_0000;
    localparam logic [DATA_W-1:0] END_RESET  = 32'h0FFF_FFFF;

    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    localparam logic [CFG_A_W-1:0] REG_CLUSTER_COUNT = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_FREE_MARKER   = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_END_MARKER    = 2'd2;

    // program steps
    localparam logic [PC_W-1:0] S_CLR     = 4'd0;
    localparam logic [PC_W-1:0] S_IDLE    = 4'd1;
    localparam logic [PC_W-1:0] S_DISP    = 4'd2;
    localparam logic [PC_W-1:0] S_RD      = 4'd3;
    localparam logic [PC_W-1:0] S_RD_OUT  = 4'd4;
    localparam logic [PC_W-1:0] S_WR      = 4'd5;
    localparam logic [PC_W-1:0] S_FR      = 4'd6;
    localparam logic [PC_W-1:0] S_RANGE   = 4'd7;
    localparam logic [PC_W-1:0] S_AL_TEST = 4'd8;
    localparam logic [PC_W-1:0] S_AL_RD   = 4'd9;
    localparam logic [PC_W-1:0] S_AL_CMP  = 4'd10;
    localparam logic [PC_W-1:0] S_AL_HIT  = 4'd11;
    localparam logic [PC_W-1:0] S_AL_FULL = 4'd12;

    // jump kinds
    localparam logic [1:0] J_NEXT = 2'd0;
    localparam logic [1:0] J_ALW  = 2'd1;
    localparam logic [1:0] J_COND = 2'd2;
    localparam logic [1:0] J_DISP = 2'd3;

    // branch conditions
    localparam logic [2:0] C_NONE      = 3'd0;
    localparam logic [2:0] C_PTR_LAST  = 3'd1;
    localparam logic [2:0] C_ACCEPT    = 3'd2;
    localparam logic [2:0] C_SCAN_END  = 3'd3;
    localparam logic [2:0] C_SCAN_OOR  = 3'd4;
    localparam logic [2:0] C_MATCH     = 3'd5;

    // pointer operations
    localparam logic [1:0] P_HOLD   = 2'd0;
    localparam logic [1:0] P_CLR    = 2'd1;
    localparam logic [1:0] P_INC    = 2'd2;
    localparam logic [1:0] P_INC_TK = 2'd3;

    // table address source
    localparam logic A_IDX = 1'b0;
    localparam logic A_PTR = 1'b1;

    // table write data source
    localparam logic [1:0] W_ZERO  = 2'd0;
    localparam logic [1:0] W_VALUE = 2'd1;
    localparam logic [1:0] W_FREE  = 2'd2;
    localparam logic [1:0] W_END   = 2'd3;

    // result data source
    localparam logic [1:0] O_ZERO  = 2'd0;
    localparam logic [1:0] O_RDATA = 2'd1;
    localparam logic [1:0] O_PTR   = 2'd2;

    typedef struct packed {
        logic            in_ready;
        logic            mem_rd;
        logic            mem_we;
        logic            addr_sel;
        logic [1:0]      wd_sel;
        logic [1:0]      ptr_op;
        logic            emit;
        logic [1:0]      out_sel;
        logic [ST_W-1:0] out_st;
        logic [1:0]      jmp;
        logic [2:0]      cond;
        logic            cond_inv;
        logic [PC_W-1:0] target;
    } t_ctrl;

    function automatic t_ctrl ucode(input logic [PC_W-1:0] pc);
        t_ctrl w;
        w = '0;
        case (pc)
            S_CLR: begin
                w.mem_we   = 1'b1;
                w.addr_sel = A_PTR;
                w.wd_sel   = W_ZERO;
                w.ptr_op   = P_INC;
                w.jmp      = J_COND;
                w.cond     = C_PTR_LAST;
                w.cond_inv = 1'b1;
                w.target   = S_CLR;
            end
            S_IDLE: begin
                w.in_ready = 1'b1;
                w.jmp      = J_COND;
                w.cond     = C_ACCEPT;
                w.cond_inv = 1'b1;
                w.target   = S_IDLE;
            end
            S_DISP: begin
                w.ptr_op = P_CLR;
                w.jmp    = J_DISP;
            end
            S_RD: begin
                w.mem_rd   = 1'b1;
                w.addr_sel = A_IDX;
            end
            S_RD_OUT: begin
                w.emit    = 1'b1;
                w.out_sel = O_RDATA;
                w.out_st  = ST_OK;
                w.jmp     = J_ALW;
                w.target  = S_IDLE;
            end
            S_WR: begin
                w.mem_we   = 1'b1;
                w.addr_sel = A_IDX;
                w.wd_sel   = W_VALUE;
                w.emit     = 1'b1;
                w.out_st   = ST_OK;
                w.jmp      = J_ALW;
                w.target   = S_IDLE;
            end
            S_FR: begin
                w.mem_we   = 1'b1;
                w.addr_sel = A_IDX;
                w.wd_sel   = W_FREE;
                w.emit     = 1'b1;
                w.out_st   = ST_OK;
                w.jmp      = J_ALW;
                w.target   = S_IDLE;
            end
            S_RANGE: begin
                w.emit   = 1'b1;
                w.out_st = ST_RANGE;
                w.jmp    = J_ALW;
                w.target = S_IDLE;
            end
            S_AL_TEST: begin
                w.jmp    = J_COND;
                w.cond   = C_SCAN_END;
                w.target = S_AL_FULL;
            end
            S_AL_RD: begin
                w.mem_rd   = 1'b1;
                w.addr_sel = A_PTR;
                w.jmp      = J_COND;
                w.cond     = C_SCAN_OOR;
                w.target   = S_RANGE;
            end
            S_AL_CMP: begin
                w.ptr_op   = P_INC_TK;
                w.jmp      = J_COND;
                w.cond     = C_MATCH;
                w.cond_inv = 1'b1;
                w.target   = S_AL_TEST;
            end
            S_AL_HIT: begin
                w.mem_we   = 1'b1;
                w.addr_sel = A_PTR;
                w.wd_sel   = W_END;
                w.emit     = 1'b1;
                w.out_sel  = O_PTR;
                w.out_st   = ST_OK;
                w.jmp      = J_ALW;
                w.target   = S_IDLE;
            end
            S_AL_FULL: begin
                w.emit   = 1'b1;
                w.out_st = ST_FULL;
                w.jmp    = J_ALW;
                w.target = S_IDLE;
            end
            default: begin
                w.jmp    = J_ALW;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/fat_entry_table_allocator.sv
// ============================================================================
// fat_entry_table_allocator
// FAT32-style cluster table with read, write, first-fit allocate and free.
// ============================================================================
// After reset the table is cleared one entry per cycle, with o_ready low;
// configuration writes are taken throughout. A microcode step counter then
// runs one command at a time over a single-port table memory. Allocate
// examines at most min(cluster_count, ENTRIES) entries, with one table read
// and one compare per entry. A finished result waits in the output register
// while the next command is taken.
`default_nettype none

`include "fat_entry_table_allocator_assert.svh"

module fat_entry_table_allocator (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire  [feta_pkg::CMD_W-1:0]    i_cmd,
    input  wire  [feta_pkg::IDX_W-1:0]    i_index,
    input  wire  [feta_pkg::DATA_W-1:0]   i_value,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic [feta_pkg::DATA_W-1:0]   o_data,
    output logic [feta_pkg::ST_W-1:0]     o_status,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire  [feta_pkg::CFG_A_W-1:0]  i_cfg_index,
    input  wire  [feta_pkg::DATA_W-1:0]   i_cfg_data
);
    import feta_pkg::*;

    logic [PC_W-1:0]   r_pc, n_pc;
    logic [SCAN_W-1:0] r_ptr, n_ptr;
    logic              r_o_valid;
    logic [DATA_W-1:0] r_o_data;
    logic [ST_W-1:0]   r_o_status;

    logic [CC_W-1:0]   r_cluster_count;
    logic [DATA_W-1:0] r_free_marker;
    logic [DATA_W-1:0] r_end_marker;

    logic [CMD_W-1:0]  r_cmd;
    logic [IDX_W-1:0]  r_index;
    logic [DATA_W-1:0] r_value;

    logic [DATA_W-1:0] r_table [ENTRIES];
    logic [DATA_W-1:0] r_rdata;

    t_ctrl             w_ctrl;
    logic              w_accept;
    logic              w_stall;
    logic              w_cond;
    logic              w_taken;
    logic              w_idx_oor;
    logic [ADDR_W-1:0] w_addr;
    logic [DATA_W-1:0] w_wdata;
    logic [DATA_W-1:0] w_odata;
    logic [PC_W-1:0]   w_disp;
    logic              w_hit_fire;

    assign w_ctrl      = ucode(r_pc);
    assign o_ready     = w_ctrl.in_ready;
    assign w_accept    = i_valid && o_ready;
    assign w_stall     = w_ctrl.emit && r_o_valid && !i_ready;
    assign w_idx_oor   = {1'b0, r_index} >= ENTRIES_IX;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_o_valid;
    assign o_data      = r_o_data;
    assign o_status    = r_o_status;
    assign w_hit_fire  = (r_pc == S_AL_HIT) && !w_stall;

    always_comb begin
        case (w_ctrl.cond)
            C_PTR_LAST: w_cond = r_ptr == LAST_SC;
            C_ACCEPT:   w_cond = w_accept;
            C_SCAN_END: w_cond = r_ptr >= SCAN_W'(r_cluster_count);
            C_SCAN_OOR: w_cond = r_ptr >= ENTRIES_SC;
            C_MATCH:    w_cond = r_rdata == r_free_marker;
            default:    w_cond = 1'b0;
        endcase
        w_taken = w_cond ^ w_ctrl.cond_inv;
    end

    always_comb begin
        if (r_cmd != CMD_ALLOC && w_idx_oor) begin
            w_disp = S_RANGE;
        end else begin
            case (r_cmd)
                CMD_READ:  w_disp = S_RD;
                CMD_WRITE: w_disp = S_WR;
                CMD_ALLOC: w_disp = S_AL_TEST;
                default:   w_disp = S_FR;
            endcase
        end
    end

    always_comb begin
        n_pc  = r_pc;
        n_ptr = r_ptr;
        if (!w_stall) begin
            case (w_ctrl.jmp)
                J_NEXT:  n_pc = r_pc + 1'b1;
                J_ALW:   n_pc = w_ctrl.target;
                J_COND:  n_pc = w_taken ? w_ctrl.target : r_pc + 1'b1;
                default: n_pc = w_disp;
            endcase
            case (w_ctrl.ptr_op)
                P_CLR:    n_ptr = '0;
                P_INC:    n_ptr = r_ptr + 1'b1;
                P_INC_TK: n_ptr = w_taken ? r_ptr + 1'b1 : r_ptr;
                default:  n_ptr = r_ptr;
            endcase
        end
    end

    always_comb begin
        w_addr = (w_ctrl.addr_sel == A_PTR) ? r_ptr[ADDR_W-1:0] : r_index[ADDR_W-1:0];
        case (w_ctrl.wd_sel)
            W_VALUE: w_wdata = r_value;
            W_FREE:  w_wdata = r_free_marker;
            W_END:   w_wdata = r_end_marker;
            default: w_wdata = '0;
        endcase
        case (w_ctrl.out_sel)
            O_RDATA: w_odata = r_rdata;
            O_PTR:   w_odata = DATA_W'(r_ptr);
            default: w_odata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= S_CLR;
            r_ptr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_pc  <= n_pc;
            r_ptr <= n_ptr;
            if (w_ctrl.emit && !w_stall) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.emit && !w_stall) begin
            r_o_data   <= w_odata;
            r_o_status <= w_ctrl.out_st;
        end
        if (w_accept) begin
            r_cmd   <= i_cmd;
            r_index <= i_index;
            r_value <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_count <= CC_RESET;
            r_free_marker   <= FREE_RESET;
            r_end_marker    <= END_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_CLUSTER_COUNT: r_cluster_count <= i_cfg_data[CC_W-1:0];
                REG_FREE_MARKER:   r_free_marker   <= i_cfg_data;
                REG_END_MARKER:    r_end_marker    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.mem_we && !w_stall) begin
            r_table[w_addr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.mem_rd) begin
            r_rdata <= r_table[w_addr];
        end
    end

    `FETA_ASSERT_IMP(a_no_transfer_in_clear, (r_pc == S_CLR), !o_ready, "transfer during clear")
    `FETA_ASSERT_IMP(a_scan_bound, (r_pc == S_AL_TEST), (r_ptr <= ENTRIES_SC), "scan past table")
    `FETA_ASSERT_NXT(a_alloc_below_count, w_hit_fire,
        (r_o_valid && r_o_data < DATA_W'(r_cluster_count)), "allocated index not below count")

endmodule

`default_nettype wire
